// File: src/ght_pkg.sv
package ght_pkg;

    typedef enum logic [2:0] {
        ACT_ALLOC   = 3'd0,
        ACT_LEASE   = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_FREE    = 3'd3,
        ACT_FIND    = 3'd4,
        ACT_COUNT   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_INVALID  = 3'd2,
        STS_DEFERRED = 3'd3,
        STS_REFUSED  = 3'd4,
        STS_FREED    = 3'd5,
        STS_NOTFOUND = 3'd6,
        STS_OVERFLOW = 3'd7
    } status_t;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_USED = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    localparam logic [15:0] GEN_MAX = 16'hFFFF;
    localparam logic [15:0] REF_MAX = 16'hFFFF;
    localparam logic [8:0]  CNT_MAX = 9'd511;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  slot;
        logic [15:0] generation;
        logic [31:0] data_word;
        logic [7:0]  type_code;
        logic        find_first;
        logic        pending_only;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_slot;
        logic [15:0] out_generation;
        logic [31:0] out_data;
        logic [8:0]  used_count;
    } out_item_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_CLEAR,
        CMD_READ,
        CMD_EXEC,
        CMD_SCAN_START,
        CMD_SCAN_STEP,
        CMD_LINK,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic retire;
    } dp_status_t;

endpackage

// File: src/ght_ctrl.sv
module ght_ctrl
    import ght_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] action,
    input  dp_status_t stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_LINK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_free;

    assign out_free = !out_valid || out_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && !out_valid)
                begin
                    cmd = CMD_LATCH;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (action == ACT_FIND || action == ACT_COUNT)
                begin
                    cmd = CMD_SCAN_START;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd = CMD_READ;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd = CMD_EXEC;
                state_next = S_LINK;
            end
            S_SCAN:
            begin
                cmd = CMD_SCAN_STEP;
                if (stat.scan_done)
                    state_next = S_DONE;
            end
            S_LINK:
            begin
                cmd = CMD_LINK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_LINK))
        else $error("exec not followed by link");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_READ))
        else $error("accept lost");

endmodule

// File: src/ght_dp.sv
module ght_dp
    import ght_pkg::*;
#(
    parameter int ENTRIES   = 256,
    parameter int DATA_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  in_item_t   in_item,
    output logic [2:0] action,
    output dp_status_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    logic [1:0]           st_mem   [ENTRIES];
    logic [15:0]          gen_mem  [ENTRIES];
    logic [15:0]          ref_mem  [ENTRIES];
    logic [DATA_BITS-1:0] data_mem [ENTRIES];
    logic [7:0]           type_mem [ENTRIES];
    logic [AW-1:0]        link_mem [ENTRIES];

    in_item_t             req_reg;
    logic [AW-1:0]        head_reg, tail_reg;
    logic [CW-1:0]        total_reg;
    logic [AW-1:0]        ptr_reg;
    logic [CW-1:0]        idx_reg;
    logic                 hit_reg, retire_reg;
    logic [8:0]           cnt_reg;
    logic [1:0]           rd_st_reg;
    logic [15:0]          rd_gen_reg, rd_ref_reg;
    logic [DATA_BITS-1:0] rd_data_reg;
    logic [7:0]           rd_type_reg;
    logic [AW-1:0]        rd_link_reg;
    logic [AW-1:0]        e_reg;
    logic                 inr_reg;
    out_item_t            res_reg;
    logic                 out_valid_reg;
    logic [AW-1:0]        clr_reg;
    logic                 sc_vld_reg;
    logic [AW-1:0]        sc_idx_reg;
    logic [1:0]           sc_st_reg;
    logic [15:0]          sc_gen_reg;
    logic [7:0]           sc_type_reg;

    logic [AW-1:0] e_sel;
    logic          inr;
    logic          genok;
    logic [15:0]   gen_inc;
    logic [AW-1:0] sidx;
    logic          sh_match;
    logic [1:0]    want;
    logic [31:0]   data_ext;
    logic [CW-1:0] scan_begin;
    logic          sc_load;

    assign action    = req_reg.action;
    assign out_valid = out_valid_reg;
    assign out_item  = res_reg;
    assign stat.clear_done = (clr_reg == LAST);
    assign stat.retire     = retire_reg;

    assign inr   = ({{(32-8){1'b0}}, req_reg.slot} < 32'(ENTRIES));
    assign e_sel = (req_reg.action == ACT_ALLOC) ? head_reg
                 : (inr ? AW'(req_reg.slot) : '0);
    assign genok   = inr_reg && (rd_gen_reg == req_reg.generation);
    assign gen_inc = (rd_gen_reg == GEN_MAX) ? 16'd1 : rd_gen_reg + 16'd1;
    assign data_ext = 32'(rd_data_reg);

    assign sidx = idx_reg[AW-1:0];
    assign want = req_reg.pending_only ? ST_PEND : ST_USED;
    assign sh_match = (req_reg.type_code == 8'd0 || req_reg.type_code == sc_type_reg);
    assign stat.scan_done = (idx_reg >= CW'(ENTRIES) && !sc_vld_reg) ||
                            (req_reg.action == ACT_FIND && hit_reg);
    assign sc_load = !stat.scan_done && (idx_reg < CW'(ENTRIES));
    assign scan_begin = req_reg.find_first ? '0
                      : (inr ? CW'(req_reg.slot) + CW'(1) : CW'(ENTRIES));

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_CLEAR:
            begin
                st_mem[clr_reg]   <= ST_FREE;
                gen_mem[clr_reg]  <= 16'd1;
                ref_mem[clr_reg]  <= '0;
                data_mem[clr_reg] <= '0;
                type_mem[clr_reg] <= '0;
                link_mem[clr_reg] <= (clr_reg == LAST) ? '0 : clr_reg + AW'(1);
            end
            CMD_LATCH:
                req_reg <= in_item;
            CMD_READ:
            begin
                e_reg       <= e_sel;
                inr_reg     <= inr;
                rd_st_reg   <= st_mem[e_sel];
                rd_gen_reg  <= gen_mem[e_sel];
                rd_ref_reg  <= ref_mem[e_sel];
                rd_data_reg <= data_mem[e_sel];
                rd_type_reg <= type_mem[e_sel];
                rd_link_reg <= link_mem[e_sel];
            end
            CMD_EXEC:
            begin
                case (req_reg.action)
                    ACT_ALLOC:
                        if (total_reg != '0)
                        begin
                            st_mem[e_reg]   <= ST_USED;
                            data_mem[e_reg] <= DATA_BITS'(req_reg.data_word);
                            type_mem[e_reg] <= req_reg.type_code;
                        end
                    ACT_LEASE:
                        if (genok && rd_st_reg == ST_USED && rd_ref_reg != REF_MAX)
                            ref_mem[e_reg] <= rd_ref_reg + 16'd1;
                    ACT_RELEASE:
                        if (genok && rd_ref_reg != 16'd0)
                        begin
                            ref_mem[e_reg] <= rd_ref_reg - 16'd1;
                            if (rd_ref_reg == 16'd1 && rd_st_reg == ST_PEND)
                            begin
                                gen_mem[e_reg]  <= gen_inc;
                                data_mem[e_reg] <= '0;
                                type_mem[e_reg] <= '0;
                                st_mem[e_reg]   <= ST_FREE;
                            end
                        end
                    ACT_FREE:
                        if (genok && rd_st_reg == ST_USED)
                        begin
                            if (rd_ref_reg != 16'd0)
                                st_mem[e_reg] <= ST_PEND;
                            else
                            begin
                                gen_mem[e_reg]  <= gen_inc;
                                data_mem[e_reg] <= '0;
                                type_mem[e_reg] <= '0;
                                st_mem[e_reg]   <= ST_FREE;
                            end
                        end
                    default:
                    begin
                    end
                endcase
            end
            CMD_LINK:
                if (retire_reg && total_reg != '0)
                    link_mem[tail_reg] <= e_reg;
            CMD_SCAN_STEP:
                if (sc_load)
                begin
                    sc_idx_reg  <= sidx;
                    sc_st_reg   <= st_mem[sidx];
                    sc_gen_reg  <= gen_mem[sidx];
                    sc_type_reg <= type_mem[sidx];
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= LAST;
            total_reg     <= CW'(ENTRIES);
            out_valid_reg <= 1'b0;
            retire_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            res_reg       <= '0;
            sc_vld_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd)
                CMD_CLEAR:
                    if (clr_reg != LAST)
                        clr_reg <= clr_reg + AW'(1);
                CMD_LATCH:
                begin
                    retire_reg <= 1'b0;
                    hit_reg    <= 1'b0;
                    res_reg    <= '{status: STS_INVALID, default: '0};
                end
                CMD_EXEC:
                begin
                    case (req_reg.action)
                        ACT_ALLOC:
                            if (total_reg == '0)
                                res_reg.status <= STS_FULL;
                            else
                            begin
                                head_reg  <= rd_link_reg;
                                total_reg <= total_reg - CW'(1);
                                res_reg.status         <= STS_OK;
                                res_reg.out_slot       <= 8'(e_reg);
                                res_reg.out_generation <= rd_gen_reg;
                            end
                        ACT_LEASE:
                            if (genok && rd_st_reg == ST_USED)
                            begin
                                if (rd_ref_reg == REF_MAX)
                                    res_reg.status <= STS_OVERFLOW;
                                else
                                begin
                                    res_reg.status   <= STS_OK;
                                    res_reg.out_data <= data_ext;
                                end
                            end
                            else if (inr_reg && rd_ref_reg != 16'd0)
                                res_reg.status <= STS_REFUSED;
                        ACT_RELEASE:
                            if (genok && rd_ref_reg != 16'd0)
                            begin
                                if (rd_ref_reg == 16'd1 && rd_st_reg == ST_PEND)
                                begin
                                    res_reg.status <= STS_FREED;
                                    retire_reg     <= 1'b1;
                                end
                                else
                                    res_reg.status <= STS_OK;
                            end
                        ACT_FREE:
                            if (genok && rd_st_reg == ST_USED)
                            begin
                                res_reg.out_data <= data_ext;
                                if (rd_ref_reg != 16'd0)
                                    res_reg.status <= STS_DEFERRED;
                                else
                                begin
                                    res_reg.status <= STS_OK;
                                    retire_reg     <= 1'b1;
                                end
                            end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_LINK:
                    if (retire_reg)
                    begin
                        if (total_reg == '0)
                            head_reg <= e_reg;
                        tail_reg <= e_reg;
                        if (total_reg < CW'(ENTRIES))
                            total_reg <= total_reg + CW'(1);
                    end
                CMD_SCAN_START:
                begin
                    hit_reg    <= 1'b0;
                    cnt_reg    <= '0;
                    sc_vld_reg <= 1'b0;
                    idx_reg    <= (req_reg.action == ACT_COUNT) ? '0 : scan_begin;
                    res_reg.status <= (req_reg.action == ACT_COUNT) ? STS_OK : STS_NOTFOUND;
                end
                CMD_SCAN_STEP:
                    if (!stat.scan_done)
                    begin
                        sc_vld_reg <= sc_load;
                        if (sc_load)
                            idx_reg <= idx_reg + CW'(1);
                        if (sc_vld_reg)
                        begin
                            if (req_reg.action == ACT_COUNT)
                            begin
                                if (sc_st_reg == ST_USED && sh_match && cnt_reg != CNT_MAX)
                                begin
                                    cnt_reg <= cnt_reg + 9'd1;
                                    res_reg.used_count <= cnt_reg + 9'd1;
                                end
                            end
                            else if (sc_st_reg == want && sh_match)
                            begin
                                hit_reg <= 1'b1;
                                ptr_reg <= sc_idx_reg;
                                res_reg.status         <= STS_OK;
                                res_reg.out_slot       <= 8'(sc_idx_reg);
                                res_reg.out_generation <= sc_gen_reg;
                            end
                        end
                    end
                CMD_RESULT:
                    out_valid_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(ENTRIES))
        else $error("free total above table size");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_RESULT) |=> out_valid_reg)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> res_reg.out_slot == 8'(ptr_reg))
        else $error("found slot mismatch");

endmodule

// File: src/generational_handle_table.sv
// Channel | Signals                          | Payload
// in      | in_valid / in_ready              | in_item  (in_item_t)
// out     | out_valid / out_ready            | out_item (out_item_t)
// Allocate, lease, release, free: accept, read, execute, free-list link,
// result, in that order.
// Find and count: accept, scan start, a scan of at most ENTRIES entries,
// result; no entry is scanned when a find-next starts past the last entry.
// After reset a clearing pass over every entry runs before the first accept.
// A result held by a stalled out channel blocks the next accept.
module generational_handle_table
    import ght_pkg::*;
#(
    parameter int ENTRIES   = 256,
    parameter int DATA_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    cmd_t       cmd;
    dp_status_t stat;
    logic [2:0] action;

    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .action    (action),
        .stat      (stat),
        .cmd       (cmd)
    );

    ght_dp #(
        .ENTRIES   (ENTRIES),
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .action    (action),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// File: tb/sv/generational_handle_table_tb.sv
`timescale 1ns / 100ps

module generational_handle_table_tb;
    import ght_pkg::*;

    localparam int          SLOTS          = 256;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 400;
    localparam int          RANDOM_PER_PH  = 357;
    localparam logic [2:0]  ACT_SPARE6     = 3'd6;
    localparam logic [2:0]  ACT_SPARE7     = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    logic [1:0]  tbl_state [SLOTS];
    logic [15:0] tbl_gen   [SLOTS];
    logic [15:0] tbl_refs  [SLOTS];
    logic [31:0] tbl_data  [SLOTS];
    logic [7:0]  tbl_type  [SLOTS];
    logic [7:0]  free_next [SLOTS];
    logic [7:0]  free_first;
    logic [7:0]  free_last;
    int          free_left;

    out_item_t   pending_results[$];
    int          mismatches;
    int          send_idle;
    int          recv_idle;
    int          stalled_cycles;

    generational_handle_table i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void table_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_state[i] = ST_FREE;
            tbl_gen[i]   = 16'd1;
            tbl_refs[i]  = '0;
            tbl_data[i]  = '0;
            tbl_type[i]  = '0;
            free_next[i] = 8'(i + 1);
        end
        free_first = '0;
        free_last  = 8'(SLOTS - 1);
        free_left  = SLOTS;
    endfunction

    function automatic void recycle(int e);
        tbl_gen[e]   = (tbl_gen[e] == GEN_MAX) ? 16'd1 : tbl_gen[e] + 16'd1;
        tbl_data[e]  = '0;
        tbl_type[e]  = '0;
        tbl_state[e] = ST_FREE;
        if (free_left == 0)
            free_first = 8'(e);
        else
            free_next[free_last] = 8'(e);
        free_last = 8'(e);
        free_left++;
    endfunction

    function automatic out_item_t apply_action(in_item_t a);
        out_item_t  r;
        int         e;
        logic       genok;
        logic [1:0] want;
        int         cnt;
        r        = '0;
        r.status = STS_INVALID;
        e        = int'(a.slot);
        genok    = (tbl_gen[e] == a.generation);
        cnt      = 0;
        case (a.action)
            ACT_ALLOC:
            begin
                if (free_left == 0)
                    r.status = STS_FULL;
                else
                begin
                    e = int'(free_first);
                    free_first = free_next[e];
                    free_left--;
                    tbl_state[e]     = ST_USED;
                    tbl_data[e]      = a.data_word;
                    tbl_type[e]      = a.type_code;
                    r.out_slot       = 8'(e);
                    r.out_generation = tbl_gen[e];
                    r.status         = STS_OK;
                end
            end
            ACT_LEASE:
            begin
                if (genok && tbl_state[e] == ST_USED)
                begin
                    if (tbl_refs[e] == REF_MAX)
                        r.status = STS_OVERFLOW;
                    else
                    begin
                        tbl_refs[e]++;
                        r.out_data = tbl_data[e];
                        r.status   = STS_OK;
                    end
                end
                else if (tbl_refs[e] != 0)
                    r.status = STS_REFUSED;
            end
            ACT_RELEASE:
            begin
                if (genok && tbl_refs[e] != 0)
                begin
                    tbl_refs[e]--;
                    r.status = STS_OK;
                    if (tbl_refs[e] == 0 && tbl_state[e] == ST_PEND)
                    begin
                        recycle(e);
                        r.status = STS_FREED;
                    end
                end
            end
            ACT_FREE:
            begin
                if (genok && tbl_state[e] == ST_USED)
                begin
                    r.out_data = tbl_data[e];
                    if (tbl_refs[e] != 0)
                    begin
                        tbl_state[e] = ST_PEND;
                        r.status     = STS_DEFERRED;
                    end
                    else
                    begin
                        recycle(e);
                        r.status = STS_OK;
                    end
                end
            end
            ACT_FIND:
            begin
                r.status = STS_NOTFOUND;
                want     = a.pending_only ? ST_PEND : ST_USED;
                for (int i = a.find_first ? 0 : e + 1; i < SLOTS; i++)
                begin
                    if (r.status == STS_NOTFOUND && tbl_state[i] == want &&
                        (a.type_code == 0 || a.type_code == tbl_type[i]))
                    begin
                        r.out_slot       = 8'(i);
                        r.out_generation = tbl_gen[i];
                        r.status         = STS_OK;
                    end
                end
            end
            ACT_COUNT:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_state[i] == ST_USED && cnt < CNT_MAX &&
                        (a.type_code == 0 || a.type_code == tbl_type[i]))
                        cnt++;
                r.used_count = 9'(cnt);
                r.status     = STS_OK;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic in_item_t make_item(logic [2:0] act, logic [7:0] s, logic [15:0] g,
                                           logic [31:0] d, logic [7:0] t, logic ff,
                                           logic po);
        in_item_t a;
        a.action       = act;
        a.slot         = s;
        a.generation   = g;
        a.data_word    = d;
        a.type_code    = t;
        a.find_first   = ff;
        a.pending_only = po;
        return a;
    endfunction

    function automatic out_item_t make_result(logic [2:0] st, logic [7:0] s, logic [15:0] g,
                                              logic [31:0] d, logic [8:0] c);
        out_item_t r;
        r.status         = st;
        r.out_slot       = s;
        r.out_generation = g;
        r.out_data       = d;
        r.used_count     = c;
        return r;
    endfunction

    function automatic in_item_t random_item();
        in_item_t a;
        int       s;
        int       pick;
        s = $urandom_range(SLOTS - 1);
        for (int k = 0; k < 8; k++)
            if (tbl_state[s] == ST_FREE)
                s = $urandom_range(SLOTS - 1);
        a.slot         = 8'(s);
        a.generation   = ($urandom_range(3) != 0) ? tbl_gen[s] : 16'($urandom_range(65535));
        a.data_word    = $urandom;
        a.type_code    = ($urandom_range(9) < 7) ? 8'($urandom_range(3))
                                                 : 8'($urandom_range(255));
        a.find_first   = 1'($urandom_range(1));
        a.pending_only = ($urandom_range(3) == 0);
        pick = $urandom_range(99);
        if (pick < 25)
            a.action = ACT_ALLOC;
        else if (pick < 45)
            a.action = ACT_LEASE;
        else if (pick < 65)
            a.action = ACT_RELEASE;
        else if (pick < 80)
            a.action = ACT_FREE;
        else if (pick < 90)
            a.action = ACT_FIND;
        else if (pick < 95)
            a.action = ACT_COUNT;
        else
            a.action = $urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7;
        return a;
    endfunction

    task automatic issue(in_item_t a, bit typed, out_item_t typed_res);
        out_item_t p;
        in_valid <= 1'b1;
        in_item  <= a;
        do
            @(posedge clk);
        while (!in_ready);
        p = apply_action(a);
        pending_results.push_back(typed ? typed_res : p);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected result: %p", got);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.out_slot !== want.out_slot ||
                got.out_generation !== want.out_generation ||
                got.out_data !== want.out_data || got.used_count !== want.used_count)
            begin
                if (mismatches < 10)
                    $display("result mismatch: expected %p actual %p", want, got);
                mismatches++;
            end
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result(out_item);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        stalled_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t  rows_in [$];
        bit        rows_typed [$];
        out_item_t rows_res [$];
        out_item_t none;

        none       = '0;
        mismatches = 0;
        send_idle  = 20;
        recv_idle  = 71;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        table_reset();

        rows_in.push_back(make_item(ACT_COUNT, 0, 0, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_OK, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_FIND, 0, 0, 0, 0, 1, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_NOTFOUND, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_ALLOC, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1, 1));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_OK, 0, 1, 0, 0));
        rows_in.push_back(make_item(ACT_ALLOC, 0, 0, 0, 1, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_OK, 1, 1, 0, 0));
        rows_in.push_back(make_item(ACT_LEASE, 0, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_OK, 0, 0, 32'hFFFF_FFFF, 0));
        rows_in.push_back(make_item(ACT_LEASE, 0, 2, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_REFUSED, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_LEASE, 1, 16'hFFFF, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_INVALID, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_FREE, 0, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_DEFERRED, 0, 0, 32'hFFFF_FFFF, 0));
        rows_in.push_back(make_item(ACT_LEASE, 0, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_REFUSED, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_FIND, 0, 0, 0, 0, 1, 1));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_OK, 0, 1, 0, 0));
        rows_in.push_back(make_item(ACT_FREE, 0, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_INVALID, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_RELEASE, 0, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_FREED, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_RELEASE, 0, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_INVALID, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_FREE, 1, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_OK, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_RELEASE, 8'hFF, 1, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_INVALID, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_FIND, 8'hFF, 0, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_NOTFOUND, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_SPARE6, 0, 0, 0, 0, 0, 0));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_INVALID, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_SPARE7, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1, 1));
        rows_typed.push_back(1);
        rows_res.push_back(make_result(STS_INVALID, 0, 0, 0, 0));
        rows_in.push_back(make_item(ACT_ALLOC, 0, 0, 32'hA5A5_5A5A, 8'hAA, 0, 0));
        rows_typed.push_back(0);
        rows_res.push_back(none);
        rows_in.push_back(make_item(ACT_ALLOC, 0, 0, 32'h0000_0001, 8'h80, 0, 0));
        rows_typed.push_back(0);
        rows_res.push_back(none);
        rows_in.push_back(make_item(ACT_FIND, 0, 0, 0, 8'hAA, 1, 0));
        rows_typed.push_back(0);
        rows_res.push_back(none);
        rows_in.push_back(make_item(ACT_FIND, 2, 0, 0, 0, 0, 0));
        rows_typed.push_back(0);
        rows_res.push_back(none);
        rows_in.push_back(make_item(ACT_COUNT, 0, 0, 0, 8'h80, 0, 0));
        rows_typed.push_back(0);
        rows_res.push_back(none);
        rows_in.push_back(make_item(ACT_COUNT, 0, 0, 0, 0, 0, 0));
        rows_typed.push_back(0);
        rows_res.push_back(none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < rows_in.size(); i++)
            issue(rows_in[i], rows_typed[i], rows_res[i]);

        // fill the table until allocation reports it full
        while (free_left != 0)
            issue(make_item(ACT_ALLOC, 0, 0, $urandom, 8'($urandom_range(3)), 0, 0), 0, none);
        issue(make_item(ACT_ALLOC, 0, 0, $urandom, 0, 0, 0), 1,
              make_result(STS_FULL, 0, 0, 0, 0));
        hold_until_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 20 : (ph == 1) ? 71 : 0;
            recv_idle = (ph == 0) ? 71 : (ph == 1) ? 20 : 0;
            repeat (RANDOM_PER_PH)
                issue(random_item(), 0, none);
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
src/ght_pkg.sv
src/ght_ctrl.sv
src/ght_dp.sv
src/generational_handle_table.sv
tb/sv/generational_handle_table_tb.sv
